// ===== rtl/core/drp_pkg.sv =====
// Shared types and constants for the DHCP reply parser.
`default_nettype none
package drp_pkg;
  localparam int unsigned MaxPacketBytes = 2048;
  localparam int unsigned DnsSlots       = 2;
  localparam logic [31:0] MagicCookie    = 32'h63825363;
  localparam logic [31:0] DefaultMask    = 32'hFFFFFF00;
  localparam logic [31:0] DefaultLease   = 32'd3600;
  localparam int unsigned HeaderBytes    = 240;
  localparam logic [7:0]  OptEnd         = 8'd255;
  localparam logic [7:0]  OptPad         = 8'd0;
  localparam logic [7:0]  OptMask        = 8'd1;
  localparam logic [7:0]  OptRouter      = 8'd3;
  localparam logic [7:0]  OptDns         = 8'd6;
  localparam logic [7:0]  OptLease       = 8'd51;
  localparam logic [7:0]  OptMsgType     = 8'd53;
  localparam logic [7:0]  OptServerId    = 8'd54;
  localparam logic [7:0]  OptT1          = 8'd58;
  localparam logic [7:0]  OptT2          = 8'd59;
  localparam logic [7:0]  MsgOffer       = 8'd2;
  localparam logic [7:0]  MsgAck         = 8'd5;
  localparam logic [7:0]  MsgNak         = 8'd6;

  typedef enum logic [1:0] {
    CFG_OWN_MAC = 2'd0, CFG_XID = 2'd1, CFG_STATE = 2'd2, CFG_OFFER_GW = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CS_OTHER = 3'd0, CS_SELECTING = 3'd1, CS_REQUESTING = 3'd2,
    CS_RENEWING = 3'd3, CS_REBINDING = 3'd4
  } client_state_t;

  typedef enum logic [1:0] {
    RK_IGNORED = 2'd0, RK_OFFER = 2'd1, RK_ACK = 2'd2, RK_NAK = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0, PH_LEN = 2'd1, PH_VALUE = 2'd2, PH_DONE = 2'd3
  } opt_phase_t;

  // Packet summary passed from the byte front end to the result stage.
  typedef struct packed {
    logic        valid_hdr;
    logic        len_ok;
    logic [7:0]  msg_type;
    logic [31:0] yiaddr;
    logic [31:0] siaddr;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [31:0] sid;
    logic [31:0] lease;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [1:0]  dns_count;
    logic [31:0] dns0;
    logic [31:0] dns1;
  } pkt_sum_t;
endpackage
`default_nettype wire

// ===== rtl/core/drp_front.sv =====
// Byte front end: header checks and option walk, one byte per cycle.
`default_nettype none
module drp_front #(
  parameter int unsigned MAX_PACKET_BYTES = drp_pkg::MaxPacketBytes,
  parameter int unsigned DNS_SLOTS        = drp_pkg::DnsSlots
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_vld,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [47:0]       own_mac,
  input  wire logic [31:0]       xid,
  output drp_pkg::pkt_sum_t      sum,
  output logic                   sum_vld
);
  import drp_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 2);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            hok_r, hok_nxt;
  logic [31:0]     hw_r, hw_nxt;
  opt_phase_t      ph_r, ph_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [7:0]      olen_r, olen_nxt;
  logic [31:0]     vs_r, vs_nxt;
  logic [7:0]      fv_r, fv_nxt;
  logic [31:0]     pend_r [2];
  logic [31:0]     pend_nxt [2];
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [31:0]     yi_r, yi_nxt, si_r, si_nxt, mask_r, mask_nxt, gw_r, gw_nxt;
  logic [31:0]     sid_r, sid_nxt, lease_r, lease_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic [7:0]      mt_r, mt_nxt;
  logic [31:0]     dns_r [2];
  logic [31:0]     dns_nxt [2];
  logic [1:0]      dcnt_r, dcnt_nxt;
  logic [31:0]     sv_vs;
  logic [7:0]      sv_fv, sv_k;
  logic [1:0]      sv_pcnt;
  logic            do_commit;
  logic [PosW-1:0] pos_inc;
  logic [5:0]      mac_sh;
  logic [7:0]      mac_b;

  always_comb begin
    pos_nxt = pos_r; hok_nxt = hok_r; hw_nxt = hw_r; ph_nxt = ph_r;
    code_nxt = code_r; rem_nxt = rem_r; olen_nxt = olen_r; vs_nxt = vs_r;
    fv_nxt = fv_r; pend_nxt = pend_r; pcnt_nxt = pcnt_r;
    yi_nxt = yi_r; si_nxt = si_r; mask_nxt = mask_r; gw_nxt = gw_r;
    sid_nxt = sid_r; lease_nxt = lease_r; t1_nxt = t1_r; t2_nxt = t2_r;
    mt_nxt = mt_r; dns_nxt = dns_r; dcnt_nxt = dcnt_r;
    sv_vs = vs_r; sv_fv = fv_r; sv_pcnt = pcnt_r; do_commit = 1'b0;
    sv_k = olen_r - rem_r;
    mac_sh = 6'd0; mac_b = 8'd0;
    pos_inc = (pos_r <= PosMax) ? pos_r + 1'b1 : pos_r;
    sum = '0;
    sum_vld = 1'b0;
    if (byte_vld) begin
      hw_nxt = {hw_r[23:0], data_byte};
      if (pos_r < PosW'(HeaderBytes)) begin
        if (pos_r == PosW'(0) && data_byte != 8'd2) hok_nxt = 1'b0;
        if (pos_r == PosW'(1) && data_byte != 8'd1) hok_nxt = 1'b0;
        if (pos_r == PosW'(2) && data_byte != 8'd6) hok_nxt = 1'b0;
        if (pos_r == PosW'(7) && hw_nxt != xid) hok_nxt = 1'b0;
        if (pos_r == PosW'(19)) yi_nxt = hw_nxt;
        if (pos_r == PosW'(23)) si_nxt = hw_nxt;
        if (pos_r >= PosW'(28) && pos_r <= PosW'(33)) begin
          mac_sh = 6'(({3'd0, 3'(PosW'(33) - pos_r)}) << 3);
          mac_b = 8'(own_mac >> mac_sh);
          if (data_byte != mac_b) hok_nxt = 1'b0;
        end
        if (pos_r == PosW'(239) && hw_nxt != MagicCookie) hok_nxt = 1'b0;
      end else if (pos_r <= PosMax) begin
        case (ph_r)
          PH_CODE: begin
            if (data_byte == OptEnd) ph_nxt = PH_DONE;
            else if (data_byte != OptPad) begin
              code_nxt = data_byte; ph_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            olen_nxt = data_byte; rem_nxt = data_byte;
            sv_vs = '0; sv_fv = '0; sv_pcnt = '0;
            if (data_byte == 8'd0) do_commit = 1'b1;
            else ph_nxt = PH_VALUE;
          end
          PH_VALUE: begin
            if (sv_k == 8'd0) sv_fv = data_byte;
            if (sv_k < 8'd4 || code_r == OptDns) sv_vs = {vs_r[23:0], data_byte};
            if (code_r == OptDns && sv_k[1:0] == 2'd3 &&
                ({1'b0, dcnt_r} + {1'b0, pcnt_r}) < 3'(DNS_SLOTS) && pcnt_r < 2'd2) begin
              pend_nxt[pcnt_r[0]] = sv_vs;
              sv_pcnt = pcnt_r + 2'd1;
            end
            rem_nxt = rem_r - 8'd1;
            if (rem_nxt == 8'd0) do_commit = 1'b1;
          end
          default: ;
        endcase
        vs_nxt = sv_vs; fv_nxt = sv_fv; pcnt_nxt = sv_pcnt;
        if (do_commit) begin
          case (code_r)
            OptMask:     if (olen_nxt >= 8'd4) mask_nxt = sv_vs;
            OptRouter:   if (olen_nxt >= 8'd4 && gw_r == '0) gw_nxt = sv_vs;
            OptDns: begin
              // copy pending addresses into free slots, in order
              if (sv_pcnt >= 2'd1 && dcnt_r < 2'd2) begin
                dns_nxt[dcnt_r[0]] = pend_nxt[0];
                dcnt_nxt = dcnt_r + 2'd1;
              end
              if (sv_pcnt >= 2'd2 && dcnt_nxt < 2'd2) begin
                dns_nxt[dcnt_nxt[0]] = pend_nxt[1];
                dcnt_nxt = dcnt_nxt + 2'd1;
              end
            end
            OptLease:    if (olen_nxt >= 8'd4) lease_nxt = sv_vs;
            OptMsgType:  if (olen_nxt >= 8'd1) mt_nxt = sv_fv;
            OptServerId: if (olen_nxt >= 8'd4) sid_nxt = sv_vs;
            OptT1:       if (olen_nxt >= 8'd4) t1_nxt = sv_vs;
            OptT2:       if (olen_nxt >= 8'd4) t2_nxt = sv_vs;
            default: ;
          endcase
          pcnt_nxt = '0;
          ph_nxt = PH_CODE;
        end
      end
      pos_nxt = pos_inc;
      if (last_byte) begin
        sum_vld = 1'b1;
        sum.valid_hdr = hok_nxt;
        sum.len_ok = pos_inc >= PosW'(HeaderBytes) && pos_inc <= PosMax;
        sum.msg_type = mt_nxt; sum.yiaddr = yi_nxt; sum.siaddr = si_nxt;
        sum.mask = mask_nxt; sum.gw = gw_nxt; sum.sid = sid_nxt;
        sum.lease = lease_nxt; sum.t1 = t1_nxt; sum.t2 = t2_nxt;
        sum.dns_count = dcnt_nxt;
        sum.dns0 = (dcnt_nxt >= 2'd1) ? dns_nxt[0] : '0;
        sum.dns1 = (dcnt_nxt >= 2'd2) ? dns_nxt[1] : '0;
        // restart for the next packet
        pos_nxt = '0; hok_nxt = 1'b1; hw_nxt = '0; ph_nxt = PH_CODE;
        code_nxt = '0; rem_nxt = '0; olen_nxt = '0; vs_nxt = '0; fv_nxt = '0;
        pend_nxt[0] = '0; pend_nxt[1] = '0; pcnt_nxt = '0;
        yi_nxt = '0; si_nxt = '0; mask_nxt = DefaultMask; gw_nxt = '0;
        sid_nxt = '0; lease_nxt = '0; t1_nxt = '0; t2_nxt = '0; mt_nxt = '0;
        dns_nxt[0] = '0; dns_nxt[1] = '0; dcnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; hok_r <= 1'b1; hw_r <= '0; ph_r <= PH_CODE;
      code_r <= '0; rem_r <= '0; olen_r <= '0; vs_r <= '0; fv_r <= '0;
      pend_r[0] <= '0; pend_r[1] <= '0; pcnt_r <= '0;
      yi_r <= '0; si_r <= '0; mask_r <= DefaultMask; gw_r <= '0;
      sid_r <= '0; lease_r <= '0; t1_r <= '0; t2_r <= '0; mt_r <= '0;
      dns_r[0] <= '0; dns_r[1] <= '0; dcnt_r <= '0;
    end else begin
      pos_r <= pos_nxt; hok_r <= hok_nxt; hw_r <= hw_nxt; ph_r <= ph_nxt;
      code_r <= code_nxt; rem_r <= rem_nxt; olen_r <= olen_nxt; vs_r <= vs_nxt;
      fv_r <= fv_nxt; pend_r <= pend_nxt; pcnt_r <= pcnt_nxt;
      yi_r <= yi_nxt; si_r <= si_nxt; mask_r <= mask_nxt; gw_r <= gw_nxt;
      sid_r <= sid_nxt; lease_r <= lease_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt;
      mt_r <= mt_nxt; dns_r <= dns_nxt; dcnt_r <= dcnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/drp_queue.sv =====
// Short queue of packet summaries between the front end and the result stage.
`default_nettype none
module drp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  drp_pkg::pkt_sum_t      wdata,
  output logic                   full,
  input  wire logic              pop,
  output drp_pkg::pkt_sum_t      rdata,
  output logic                   empty
);
  import drp_pkg::*;
  localparam int unsigned AW = $clog2(DEPTH);

  pkt_sum_t          mem_r [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/drp_back.sv =====
// Result stage: gating by client state and default fill-in, registered output.
`default_nettype none
module drp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              sum_vld,
  input  drp_pkg::pkt_sum_t      sum,
  output logic                   sum_pop,
  input  wire logic [2:0]        client_state,
  input  wire logic [31:0]       offer_gateway,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [1:0]             out_result_kind,
  output logic [31:0]            out_your_ip,
  output logic [31:0]            out_server_ip,
  output logic [31:0]            out_netmask,
  output logic [31:0]            out_gateway,
  output logic [31:0]            out_lease_seconds,
  output logic [31:0]            out_renew_seconds,
  output logic [31:0]            out_rebind_seconds,
  output logic [1:0]             out_dns_count,
  output logic [31:0]            out_dns_first,
  output logic [31:0]            out_dns_second
);
  import drp_pkg::*;

  logic         vld_r, vld_nxt;
  result_kind_t kind;
  logic         waiting, load;
  logic [31:0]  lease, t1, t2, gw, sid;
  logic [34:0]  l7;

  assign load    = sum_vld && (!vld_r || out_pop);
  assign sum_pop = load;
  assign out_empty = !vld_r;

  always_comb begin
    waiting = client_state == CS_REQUESTING || client_state == CS_RENEWING ||
              client_state == CS_REBINDING;
    kind = RK_IGNORED;
    if (sum.valid_hdr && sum.len_ok) begin
      if (sum.msg_type == MsgOffer && client_state == CS_SELECTING && sum.yiaddr != '0)
        kind = RK_OFFER;
      else if (sum.msg_type == MsgAck && waiting) kind = RK_ACK;
      else if (sum.msg_type == MsgNak && waiting) kind = RK_NAK;
    end
    lease = (sum.lease == '0) ? DefaultLease : sum.lease;
    l7 = {lease, 3'd0} - {3'd0, lease};
    t1 = (sum.t1 == '0) ? {1'b0, lease[31:1]} : sum.t1;
    t2 = (sum.t2 == '0) ? l7[34:3] : sum.t2;
    sid = (sum.sid == '0) ? sum.siaddr : sum.sid;
    gw = (kind == RK_ACK && sum.gw == '0) ? offer_gateway : sum.gw;
    vld_nxt = vld_r;
    if (out_pop && vld_r) vld_nxt = 1'b0;
    if (load) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    if (load) begin
      out_result_kind <= kind;
      if (kind == RK_OFFER || kind == RK_ACK) begin
        out_your_ip <= sum.yiaddr; out_server_ip <= sid; out_netmask <= sum.mask;
        out_gateway <= gw; out_lease_seconds <= lease; out_renew_seconds <= t1;
        out_rebind_seconds <= t2; out_dns_count <= sum.dns_count;
        out_dns_first <= sum.dns0; out_dns_second <= sum.dns1;
      end else begin
        out_your_ip <= '0; out_server_ip <= '0; out_netmask <= '0;
        out_gateway <= '0; out_lease_seconds <= '0; out_renew_seconds <= '0;
        out_rebind_seconds <= '0; out_dns_count <= '0;
        out_dns_first <= '0; out_dns_second <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dhcp_reply_parser_core.sv =====
// DHCP client reply parser, top level.
//
// Input channel: one payload byte a beat (in_data_byte, in_last_byte), taken
// when in_push is high and in_full is low. The front end checks the fixed
// header and walks the option list at one byte per cycle, so back-to-back
// bytes run at full rate while in_full is low. The beat marked last closes
// the packet and pushes a summary into a four-entry queue.
// Result channel: one result per packet. It passes the queue write, then the
// registered result stage once its output register is free, and is taken
// when out_pop is high and out_empty is low.
// While results are not taken the queue fills; in_full rises only once it
// holds four summaries and the output register is occupied, so up to five
// packets may be finished without a pop.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while idle.
// Reset (synchronous, rst_n low) clears the configuration and parse state, sets
// the netmask default to 255.255.255.0 and empties the queue and output stage.
`default_nettype none
module dhcp_reply_parser_core #(
  parameter int unsigned MAX_PACKET_BYTES = drp_pkg::MaxPacketBytes,
  parameter int unsigned DNS_SLOTS        = drp_pkg::DnsSlots
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_your_ip,
  output logic [31:0]      out_server_ip,
  output logic [31:0]      out_netmask,
  output logic [31:0]      out_gateway,
  output logic [31:0]      out_lease_seconds,
  output logic [31:0]      out_renew_seconds,
  output logic [31:0]      out_rebind_seconds,
  output logic [1:0]       out_dns_count,
  output logic [31:0]      out_dns_first,
  output logic [31:0]      out_dns_second
);
  import drp_pkg::*;

  logic [47:0] own_mac_r;
  logic [31:0] xid_r, ogw_r;
  logic [2:0]  cs_r;
  pkt_sum_t    fsum, qsum;
  logic        fvld, qfull, qempty, qpop, acc;

  assign cfg_ready = 1'b1;
  assign in_full = qfull;
  assign acc = in_push && !qfull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0; xid_r <= '0; cs_r <= '0; ogw_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_MAC:  own_mac_r <= cfg_data;
        CFG_XID:      xid_r <= cfg_data[31:0];
        CFG_STATE:    cs_r <= cfg_data[2:0];
        CFG_OFFER_GW: ogw_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  drp_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES), .DNS_SLOTS(DNS_SLOTS)) u_front (
    .clk, .rst_n, .byte_vld(acc), .data_byte(in_data_byte), .last_byte(in_last_byte),
    .own_mac(own_mac_r), .xid(xid_r), .sum(fsum), .sum_vld(fvld)
  );

  drp_queue #(.DEPTH(4)) u_queue (
    .clk, .rst_n, .push(fvld), .wdata(fsum), .full(qfull),
    .pop(qpop), .rdata(qsum), .empty(qempty)
  );

  drp_back u_back (
    .clk, .rst_n, .sum_vld(!qempty), .sum(qsum), .sum_pop(qpop),
    .client_state(cs_r), .offer_gateway(ogw_r),
    .out_empty, .out_pop, .out_result_kind, .out_your_ip, .out_server_ip,
    .out_netmask, .out_gateway, .out_lease_seconds, .out_renew_seconds,
    .out_rebind_seconds, .out_dns_count, .out_dns_first, .out_dns_second
  );
endmodule
`default_nettype wire

// ===== rtl/core/drp_checker.sv =====
// Port-level checker for the DHCP reply parser, bound to the top level.
`default_nettype none
module drp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        cfg_ready,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_result_kind,
  input wire logic [31:0] out_your_ip,
  input wire logic [31:0] out_lease_seconds
);
  import drp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_kind)))
    else $error("waiting result changed");
  a_offer_ip: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == RK_OFFER) |-> out_your_ip != '0)
    else $error("offer with zero address");
  a_lease: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_result_kind == RK_OFFER || out_result_kind == RK_ACK))
    |-> out_lease_seconds != '0)
    else $error("bound result with zero lease");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");
endmodule

bind dhcp_reply_parser_core drp_checker u_drp_checker (
  .clk, .rst_n, .in_push, .in_full, .cfg_ready, .out_empty, .out_pop,
  .out_result_kind, .out_your_ip, .out_lease_seconds
);
`default_nettype wire

// ===== tb/sv/dhcp_reply_checker.sv =====
// Scoreboard for the DHCP reply parser: predicts each reply and compares it.
`timescale 1ns / 1ps
module dhcp_reply_checker
  import drp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_result_kind,
  input  logic [31:0] out_your_ip,
  input  logic [31:0] out_server_ip,
  input  logic [31:0] out_netmask,
  input  logic [31:0] out_gateway,
  input  logic [31:0] out_lease_seconds,
  input  logic [31:0] out_renew_seconds,
  input  logic [31:0] out_rebind_seconds,
  input  logic [1:0]  out_dns_count,
  input  logic [31:0] out_dns_first,
  input  logic [31:0] out_dns_second,
  output int          fail_count,
  output int          replies_pending,
  output int          offers_seen,
  output int          acks_seen,
  output int          naks_seen,
  output int          ignored_seen
);

  localparam int WYi = 0, WSi = 1, WMask = 2, WGw = 3, WSid = 4, WLease = 5,
                 WT1 = 6, WT2 = 7;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  your_ip;
    logic [31:0]  server_ip;
    logic [31:0]  netmask;
    logic [31:0]  gateway;
    logic [31:0]  lease;
    logic [31:0]  renew;
    logic [31:0]  rebind;
    logic [1:0]   dns_n;
    logic [31:0]  dns0;
    logic [31:0]  dns1;
  } reply_t;

  reply_t replies_due[$];

  // register copies
  logic [47:0] own_mac;
  logic [31:0] own_xid;
  logic [2:0]  cl_state;
  logic [31:0] offer_gw;

  // per-packet parse state
  logic [11:0]  pos;
  logic         hdr_ok;
  logic [31:0]  hdr_word;
  opt_phase_t   phase;
  logic [7:0]   opt_code;
  logic [7:0]   opt_rem;
  logic [7:0]   opt_len;
  logic [31:0]  shift_word;
  logic [7:0]   first_val;
  logic [31:0]  dns_pend [2];
  int           pend_cnt;
  logic [31:0]  words [8];
  logic [7:0]   msg_type;
  logic [31:0]  dns_kept [2];
  int           dns_n;

  function automatic void clear_packet();
    pos = '0;
    hdr_ok = 1'b1;
    hdr_word = '0;
    phase = PH_CODE;
    opt_code = '0;
    opt_rem = '0;
    opt_len = '0;
    shift_word = '0;
    first_val = '0;
    dns_pend[0] = '0;
    dns_pend[1] = '0;
    pend_cnt = 0;
    foreach (words[i]) words[i] = '0;
    words[WMask] = DefaultMask;
    msg_type = '0;
    dns_kept[0] = '0;
    dns_kept[1] = '0;
    dns_n = 0;
  endfunction

  function automatic void take_header_byte(int p, logic [7:0] b);
    if (p == 0 && b != 8'd2) hdr_ok = 1'b0;
    if (p == 1 && b != 8'd1) hdr_ok = 1'b0;
    if (p == 2 && b != 8'd6) hdr_ok = 1'b0;
    if (p == 7 && hdr_word != own_xid) hdr_ok = 1'b0;
    if (p == 19) words[WYi] = hdr_word;
    if (p == 23) words[WSi] = hdr_word;
    if (p >= 28 && p <= 33 && b != own_mac[8*(33-p) +: 8]) hdr_ok = 1'b0;
    if (p == 239 && hdr_word != MagicCookie) hdr_ok = 1'b0;
  endfunction

  function automatic void close_option();
    bit four;
    four = opt_len >= 8'd4;
    case (opt_code)
      OptMask:     if (four) words[WMask] = shift_word;
      OptRouter:   if (four && words[WGw] == 0) words[WGw] = shift_word;
      OptDns:
        for (int i = 0; i < pend_cnt && i < 2 && dns_n < 2; i++) begin
          dns_kept[dns_n] = dns_pend[i];
          dns_n++;
        end
      OptLease:    if (four) words[WLease] = shift_word;
      OptMsgType:  if (opt_len >= 8'd1) msg_type = first_val;
      OptServerId: if (four) words[WSid] = shift_word;
      OptT1:       if (four) words[WT1] = shift_word;
      OptT2:       if (four) words[WT2] = shift_word;
      default: ;
    endcase
    pend_cnt = 0;
    phase = PH_CODE;
  endfunction

  function automatic void walk_option(logic [7:0] b);
    logic [7:0] k;
    case (phase)
      PH_CODE:
        if (b == OptEnd) phase = PH_DONE;
        else if (b != OptPad) begin
          opt_code = b;
          phase = PH_LEN;
        end
      PH_LEN: begin
        opt_len = b;
        opt_rem = b;
        shift_word = '0;
        first_val = '0;
        pend_cnt = 0;
        if (b == 8'd0) close_option();
        else phase = PH_VALUE;
      end
      PH_VALUE: begin
        k = opt_len - opt_rem;
        if (k == 8'd0) first_val = b;
        if (k < 8'd4 || opt_code == OptDns) shift_word = {shift_word[23:0], b};
        // queue each complete DNS address while free slots remain
        if (opt_code == OptDns && k[1:0] == 2'd3 && dns_n + pend_cnt < DnsSlots &&
            pend_cnt < 2) begin
          dns_pend[pend_cnt] = shift_word;
          pend_cnt++;
        end
        opt_rem = opt_rem - 8'd1;
        if (opt_rem == 8'd0) close_option();
      end
      default: ;
    endcase
  endfunction

  function automatic reply_t finish_packet();
    reply_t r;
    bit waiting;
    logic [63:0] lease7;
    r = '0;
    r.kind = RK_IGNORED;
    if (pos >= HeaderBytes && pos <= MaxPacketBytes && hdr_ok) begin
      waiting = cl_state >= CS_REQUESTING && cl_state <= CS_REBINDING;
      if (msg_type == MsgOffer && cl_state == CS_SELECTING && words[WYi] != 0)
        r.kind = RK_OFFER;
      else if (msg_type == MsgAck && waiting) r.kind = RK_ACK;
      else if (msg_type == MsgNak && waiting) r.kind = RK_NAK;
    end
    if (r.kind == RK_OFFER || r.kind == RK_ACK) begin
      r.lease = words[WLease] == 0 ? DefaultLease : words[WLease];
      lease7 = 64'(r.lease) * 7;
      r.renew = words[WT1] == 0 ? r.lease / 2 : words[WT1];
      r.rebind = words[WT2] == 0 ? 32'(lease7 / 8) : words[WT2];
      r.server_ip = words[WSid] == 0 ? words[WSi] : words[WSid];
      r.gateway = words[WGw];
      if (r.kind == RK_ACK && r.gateway == 0) r.gateway = offer_gw;
      r.your_ip = words[WYi];
      r.netmask = words[WMask];
      r.dns_n = 2'(dns_n);
      r.dns0 = dns_n >= 1 ? dns_kept[0] : '0;
      r.dns1 = dns_n >= 2 ? dns_kept[1] : '0;
    end
    return r;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    int p;
    p = pos;
    hdr_word = {hdr_word[23:0], b};
    if (p < HeaderBytes) take_header_byte(p, b);
    else if (p <= MaxPacketBytes) walk_option(b);
    if (pos <= MaxPacketBytes) pos = pos + 12'd1;
    if (last) begin
      replies_due.push_back(finish_packet());
      clear_packet();
    end
  endfunction

  function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, nm, want, got);
    end
  endfunction

  function automatic void check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("[%0t] reply with none outstanding", $realtime);
      return;
    end
    want = replies_due.pop_front();
    case (want.kind)
      RK_OFFER: offers_seen++;
      RK_ACK:   acks_seen++;
      RK_NAK:   naks_seen++;
      default:  ignored_seen++;
    endcase
    check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
    check_field("your_ip", want.your_ip, out_your_ip);
    check_field("server_ip", want.server_ip, out_server_ip);
    check_field("netmask", want.netmask, out_netmask);
    check_field("gateway", want.gateway, out_gateway);
    check_field("lease_seconds", want.lease, out_lease_seconds);
    check_field("renew_seconds", want.renew, out_renew_seconds);
    check_field("rebind_seconds", want.rebind, out_rebind_seconds);
    check_field("dns_count", 32'(want.dns_n), 32'(out_dns_count));
    check_field("dns_first", want.dns0, out_dns_first);
    check_field("dns_second", want.dns1, out_dns_second);
  endfunction

  initial begin
    fail_count = 0;
    replies_pending = 0;
    offers_seen = 0;
    acks_seen = 0;
    naks_seen = 0;
    ignored_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      own_mac <= '0;
      own_xid <= '0;
      cl_state <= '0;
      offer_gw <= '0;
      clear_packet();
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OWN_MAC:  own_mac <= cfg_data;
          CFG_XID:      own_xid <= cfg_data[31:0];
          CFG_STATE:    cl_state <= cfg_data[2:0];
          CFG_OFFER_GW: offer_gw <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) parse_byte(in_data_byte, in_last_byte);
      if (out_pop && !out_empty) check_reply();
    end
    replies_pending = replies_due.size();
  end

endmodule

// ===== tb/sv/dhcp_reply_parser_core_tb.sv =====
// Testbench top for the DHCP reply parser: stimulus, idling and verdict.
`timescale 1ns / 1ps
module dhcp_reply_parser_core_tb;
  import drp_pkg::*;

  localparam int CycleLimit = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        out_pop = 1'b0;
  logic        in_full, cfg_ready, out_empty;
  logic [1:0]  out_result_kind, out_dns_count;
  logic [31:0] out_your_ip, out_server_ip, out_netmask, out_gateway;
  logic [31:0] out_lease_seconds, out_renew_seconds, out_rebind_seconds;
  logic [31:0] out_dns_first, out_dns_second;

  int fail_count, replies_pending, offers_seen, acks_seen, naks_seen, ignored_seen;

  int   tx_idle = 24;
  int   rx_idle = 53;
  logic hold_rx = 1'b0;
  logic stall_req = 1'b0;
  int   cycles = 0;

  logic [47:0] mac_r;
  logic [31:0] xid_r;
  logic [2:0]  state_r;
  logic [7:0]  pkt [$];

  dhcp_reply_parser_core DUT (.*);
  dhcp_reply_checker scoreboard (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) out_pop <= !hold_rx && ($urandom_range(99) >= rx_idle);

  // long receiver hold-off so the result queue fills and in_full rises
  initial begin
    wait (stall_req);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [47:0] mac, input logic [31:0] xid,
                           input logic [2:0] st, input logic [31:0] gw);
    drain();
    mac_r = mac;
    xid_r = xid;
    state_r = st;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      case (cfg_idx_t'(i))
        CFG_OWN_MAC:  cfg_data <= mac;
        CFG_XID:      cfg_data <= {16'h0, xid};
        CFG_STATE:    cfg_data <= {45'h0, st};
        default:      cfg_data <= {16'h0, gw};
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 100000));
      default: return $urandom;
    endcase
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) pkt.push_back(v[8*i +: 8]);
  endfunction

  function automatic void word_option(logic [7:0] code, logic [31:0] v);
    pkt.push_back(code);
    pkt.push_back(8'd4);
    put32(v);
  endfunction

  function automatic void raw_option(logic [7:0] code, int len);
    pkt.push_back(code);
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
  endfunction

  function automatic void make_header(logic [31:0] yi);
    pkt.delete();
    pkt.push_back(8'd2);
    pkt.push_back(8'd1);
    pkt.push_back(8'd6);
    pkt.push_back(8'($urandom));
    put32(xid_r);
    repeat (8) pkt.push_back(8'($urandom));
    put32(yi);
    put32(rand_word());
    put32($urandom);
    for (int i = 5; i >= 0; i--) pkt.push_back(mac_r[8*i +: 8]);
    while (pkt.size() < 236) pkt.push_back(8'($urandom));
    put32(MagicCookie);
  endfunction

  function automatic void add_options(logic [7:0] mtype);
    int n, at;
    logic [7:0] shortc [6];
    shortc = '{OptMask, OptRouter, OptLease, OptServerId, OptT1, OptT2};
    n = $urandom_range(0, 8);
    at = $urandom_range(0, n);
    for (int i = 0; i <= n; i++) begin
      if (i == at) begin
        pkt.push_back(OptMsgType);
        pkt.push_back(8'd1);
        pkt.push_back(mtype);
      end else begin
        case ($urandom_range(0, 11))
          0: repeat ($urandom_range(1, 3)) pkt.push_back(OptPad);
          1: word_option(OptMask, rand_word());
          2: begin
            pkt.push_back(OptRouter);
            pkt.push_back($urandom_range(0, 1) ? 8'd4 : 8'd8);
            put32(rand_word());
            if (pkt[pkt.size() - 5] == 8'd8) put32(rand_word());
          end
          3: raw_option(OptDns, 4 * $urandom_range(0, 3) +
                        ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0));
          4: word_option(OptLease, rand_word());
          5: word_option(OptT1, rand_word());
          6: word_option(OptT2, rand_word());
          7: word_option(OptServerId, rand_word());
          8: raw_option(shortc[$urandom_range(0, 5)], $urandom_range(0, 3));
          9: raw_option(OptMsgType, $urandom_range(0, 2));
          10: raw_option(8'($urandom_range(1, 254)), $urandom_range(0, 8));
          default: raw_option(OptDns, 4 * $urandom_range(1, 3));
        endcase
      end
    end
    if ($urandom_range(0, 7) != 0) pkt.push_back(OptEnd);
    repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
  endfunction

  function automatic void reply_to(logic [7:0] mtype, logic [31:0] yi);
    make_header(yi);
    add_options(mtype);
  endfunction

  // pick the message type that the current client state acts on, mostly
  function automatic logic [7:0] fitting_type();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 9));
    if (state_r == CS_SELECTING) return MsgOffer;
    return ($urandom_range(0, 9) < 7) ? MsgAck : MsgNak;
  endfunction

  initial begin
    logic [31:0] yi;
    int sel;
    int blocks;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: header checks, lengths and truncation while selecting
    configure(48'h0, 32'h0, CS_SELECTING, 32'h0);
    reply_to(MsgOffer, 32'h0A00_0005);
    send_packet();
    reply_to(MsgOffer, 32'h0);
    send_packet();
    for (int j = 0; j < 6; j++) begin
      reply_to(MsgOffer, 32'hC0A8_0101);
      case (j)
        0: pkt[0] = 8'd1;
        1: pkt[1] = 8'd6;
        2: pkt[2] = 8'd1;
        3: pkt[5] = pkt[5] ^ 8'h01;
        4: pkt[30] = pkt[30] ^ 8'h80;
        default: pkt[239] = pkt[239] ^ 8'h01;
      endcase
      send_packet();
    end
    reply_to(MsgOffer, 32'h1);
    while (pkt.size() > 100) void'(pkt.pop_back());
    send_packet();
    make_header(32'h2);
    send_packet();
    // lease option cut off after two and after three value bytes, then complete
    for (int j = 0; j < 3; j++) begin
      make_header(32'h3);
      pkt.push_back(OptMsgType);
      pkt.push_back(8'd1);
      pkt.push_back(MsgOffer);
      word_option(OptLease, 32'd77);
      while (pkt.size() > 247 + j) void'(pkt.pop_back());
      send_packet();
    end
    // lengths at and just past the limit, then well past it
    foreach (sel_len[i]) begin
      reply_to(MsgOffer, 32'hFFFF_FFFF);
      while (pkt.size() < sel_len[i]) pkt.push_back(OptPad);
      send_packet();
    end
    reply_to(MsgAck, 32'h4);
    send_packet();

    configure(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, CS_REQUESTING, 32'hFFFF_FFFF);
    make_header(32'h0A00_0009);
    pkt.push_back(OptMsgType);
    pkt.push_back(8'd1);
    pkt.push_back(MsgAck);
    raw_option(OptDns, 12);
    raw_option(OptDns, 4);
    pkt.push_back(OptEnd);
    send_packet();
    reply_to(MsgNak, 32'h5);
    send_packet();
    reply_to(MsgOffer, 32'h6);
    send_packet();
    configure(48'h0123_4567_89AB, 32'h8000_0001, 3'd6, 32'h0101_0101);
    reply_to(MsgAck, 32'h7);
    send_packet();

    // random blocks: mostly well-formed replies, some noise
    blocks = 9;
    for (int blk = 0; blk < blocks; blk++) begin
      if (blk == 3) begin
        tx_idle = 53;
        rx_idle = 24;
      end else if (blk == 6) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      configure({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, rand_word(),
                ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                           : 3'($urandom_range(0, 7)),
                rand_word());
      if (blk == 4) begin
        stall_req <= 1'b1;
        repeat (14) begin
          pkt.delete();
          repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
          send_packet();
        end
      end
      repeat (8) begin
        yi = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
        reply_to(fitting_type(), yi);
        sel = $urandom_range(0, 19);
        if (sel < 2) pkt[$urandom_range(0, 239)] ^= 8'(1 << $urandom_range(0, 7));
        else if (sel == 2)
          while (pkt.size() > $urandom_range(1, 239)) void'(pkt.pop_back());
        send_packet();
      end
    end

    drain();
    $display("Covered %0d offers, %0d acks, %0d naks and %0d ignored packets,",
             offers_seen, acks_seen, naks_seen, ignored_seen);
    $display("with header faults, truncation, length limits and a full-queue stall.");
    if (fail_count == 0 && replies_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  int sel_len [3] = '{2048, 2049, 2100};

endmodule
